// ===== design/itoa_pkg.sv =====
// Shared constants, types and command/status structs for the integer-to-text block.
package itoa_pkg;

  // Input word and conversion sizes
  localparam int VALUE_BITS  = 32;
  localparam int MAX_DIGITS  = 16;
  localparam int CHAR_SLOTS  = 16;
  localparam int CHAR_W      = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int RADIX_W     = 5;
  localparam int DIGIT_W     = $clog2(CHAR_SLOTS);
  localparam int NUM_CELLS   = VALUE_BITS;
  localparam int CELL_IDX_W  = $clog2(NUM_CELLS);
  localparam int BIT_CNT_W   = $clog2(VALUE_BITS);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH  = 2'd2;

  // Characters that may not appear in the alphabet
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CONVERT,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic convert;
    logic emit_sign;
    logic emit_digit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic alpha_ok;
    logic neg;
    logic conv_done;
    logic emit_done;
  } dp_status_t;

endpackage

// ===== design/itoa_ctrl.sv =====
// Sequencer that steps each word through check, conversion and character output.
module itoa_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  itoa_pkg::dp_status_t  status,
  output itoa_pkg::ctrl_cmd_t   cmd,
  output logic                  busy
);

  itoa_pkg::state_t state;
  itoa_pkg::state_t state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itoa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance state
  always_comb begin
    state_next = state;
    case (state)
      itoa_pkg::ST_IDLE: begin
        if (start) begin
          state_next = itoa_pkg::ST_CHECK;
        end
      end
      itoa_pkg::ST_CHECK: begin
        state_next = status.alpha_ok ? itoa_pkg::ST_CONVERT : itoa_pkg::ST_IDLE;
      end
      itoa_pkg::ST_CONVERT: begin
        if (status.conv_done) begin
          state_next = status.neg ? itoa_pkg::ST_SIGN : itoa_pkg::ST_EMIT;
        end
      end
      itoa_pkg::ST_SIGN: begin
        state_next = itoa_pkg::ST_EMIT;
      end
      itoa_pkg::ST_EMIT: begin
        if (status.emit_done) begin
          state_next = itoa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = itoa_pkg::ST_IDLE;
      end
    endcase
  end

  // Drive datapath commands
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      itoa_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      itoa_pkg::ST_CHECK: begin
      end
      itoa_pkg::ST_CONVERT: begin
        cmd.convert = 1'b1;
      end
      itoa_pkg::ST_SIGN: begin
        cmd.emit_sign = 1'b1;
      end
      itoa_pkg::ST_EMIT: begin
        cmd.emit_digit = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

// ===== design/itoa_dp.sv =====
// Datapath: alphabet check, bit-serial radix conversion cells and output word register.
module itoa_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  itoa_pkg::ctrl_cmd_t                   cmd,
  input  logic signed [itoa_pkg::VALUE_BITS-1:0] value,
  input  logic [itoa_pkg::RADIX_W-1:0]          digit_count,
  input  logic [itoa_pkg::CFG_DATA_W-1:0]       digit_chars_low,
  input  logic [itoa_pkg::CFG_DATA_W-1:0]       digit_chars_high,
  output itoa_pkg::dp_status_t                  status,
  output logic [itoa_pkg::CHAR_W-1:0]           text_char,
  output logic                                  last_char,
  output logic                                  strobe
);

  logic [itoa_pkg::CHAR_W-1:0]      alpha [itoa_pkg::CHAR_SLOTS];
  logic [2*itoa_pkg::CFG_DATA_W-1:0] chars_all;
  logic                              alpha_bad;
  logic                              alpha_ok;

  logic [itoa_pkg::VALUE_BITS-1:0]  mag;
  logic                             neg;
  logic [itoa_pkg::BIT_CNT_W-1:0]   bit_cnt;
  logic [itoa_pkg::DIGIT_W-1:0]     cells      [itoa_pkg::NUM_CELLS];
  logic [itoa_pkg::DIGIT_W-1:0]     cells_next [itoa_pkg::NUM_CELLS];
  logic [itoa_pkg::NUM_CELLS-1:0]   nz_next;
  logic [itoa_pkg::CELL_IDX_W-1:0]  top;
  logic [itoa_pkg::CELL_IDX_W-1:0]  top_next;
  logic [itoa_pkg::CELL_IDX_W-1:0]  idx;

  logic [itoa_pkg::NUM_CELLS-1:0]   gen;
  logic [itoa_pkg::NUM_CELLS-1:0]   prop;
  logic [itoa_pkg::NUM_CELLS:0]     carry_sum;
  logic [itoa_pkg::NUM_CELLS:0]     carries;
  logic [itoa_pkg::RADIX_W-1:0]     radix_m1;

  // Unpack the alphabet bytes
  assign chars_all = {digit_chars_high, digit_chars_low};
  always_comb begin
    for (int i = 0; i < itoa_pkg::CHAR_SLOTS; i++) begin
      alpha[i] = chars_all[itoa_pkg::CHAR_W*i +: itoa_pkg::CHAR_W];
    end
  end

  // Check count, forbidden bytes and repeats over the active characters
  always_comb begin
    alpha_bad = (digit_count < itoa_pkg::RADIX_W'(2)) ||
                (digit_count > itoa_pkg::RADIX_W'(itoa_pkg::MAX_DIGITS));
    for (int a = 0; a < itoa_pkg::CHAR_SLOTS; a++) begin
      if (itoa_pkg::RADIX_W'(a) < digit_count) begin
        if (alpha[a] == itoa_pkg::CHAR_PLUS || alpha[a] == itoa_pkg::CHAR_MINUS ||
            alpha[a] == itoa_pkg::CHAR_SPACE ||
            (alpha[a] >= itoa_pkg::CHAR_TAB && alpha[a] <= itoa_pkg::CHAR_CR)) begin
          alpha_bad = 1'b1;
        end
        for (int b = a + 1; b < itoa_pkg::CHAR_SLOTS; b++) begin
          if (itoa_pkg::RADIX_W'(b) < digit_count && alpha[b] == alpha[a]) begin
            alpha_bad = 1'b1;
          end
        end
      end
    end
  end

  // Register the alphabet verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_ok <= 1'b0;
    end else begin
      alpha_ok <= !alpha_bad;
    end
  end

  // Per-cell generate and propagate for doubling plus incoming bit
  assign radix_m1 = digit_count - itoa_pkg::RADIX_W'(1);
  always_comb begin
    for (int i = 0; i < itoa_pkg::NUM_CELLS; i++) begin
      gen[i]  = {cells[i], 1'b0} >= digit_count;
      prop[i] = {cells[i], 1'b0} == radix_m1;
    end
  end

  // Resolve the cell carries as one add; bit i is the carry into cell i
  assign carry_sum = {1'b0, gen | prop} + {1'b0, gen} +
                     {{itoa_pkg::NUM_CELLS{1'b0}}, mag[itoa_pkg::VALUE_BITS-1]};
  assign carries   = carry_sum ^ {1'b0, gen | prop} ^ {1'b0, gen};

  // Update each digit cell: 2d + c, reduced by the radix on carry out
  always_comb begin
    logic [itoa_pkg::RADIX_W-1:0] t;
    logic [itoa_pkg::RADIX_W-1:0] t_red;
    for (int i = 0; i < itoa_pkg::NUM_CELLS; i++) begin
      t     = {cells[i], carries[i]};
      t_red = t - digit_count;
      cells_next[i] = carries[i+1] ? t_red[itoa_pkg::DIGIT_W-1:0] : t[itoa_pkg::DIGIT_W-1:0];
      nz_next[i]    = cells_next[i] != '0;
    end
  end

  // Grow the top digit position when the cell above turns nonzero
  always_comb begin
    top_next = top;
    if (top != itoa_pkg::CELL_IDX_W'(itoa_pkg::NUM_CELLS - 1)) begin
      if (nz_next[top + itoa_pkg::CELL_IDX_W'(1)]) begin
        top_next = top + itoa_pkg::CELL_IDX_W'(1);
      end
    end
  end

  // Load, convert and walk the digit cells
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg     <= value[itoa_pkg::VALUE_BITS-1];
      mag     <= value[itoa_pkg::VALUE_BITS-1] ? (~value + 1'b1) : value;
      bit_cnt <= '0;
      top     <= '0;
      for (int i = 0; i < itoa_pkg::NUM_CELLS; i++) begin
        cells[i] <= '0;
      end
    end else if (cmd.convert) begin
      mag     <= {mag[itoa_pkg::VALUE_BITS-2:0], 1'b0};
      bit_cnt <= bit_cnt + itoa_pkg::BIT_CNT_W'(1);
      top     <= top_next;
      idx     <= top_next;
      for (int i = 0; i < itoa_pkg::NUM_CELLS; i++) begin
        cells[i] <= cells_next[i];
      end
    end else if (cmd.emit_digit) begin
      idx <= idx - itoa_pkg::CELL_IDX_W'(1);
    end
  end

  // Register the output word
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_sign || cmd.emit_digit;
    end
    text_char <= cmd.emit_sign ? itoa_pkg::CHAR_MINUS : alpha[cells[idx]];
    last_char <= cmd.emit_digit && (idx == '0);
  end

  assign status.alpha_ok  = alpha_ok;
  assign status.neg       = neg;
  assign status.conv_done = bit_cnt == itoa_pkg::BIT_CNT_W'(itoa_pkg::VALUE_BITS - 1);
  assign status.emit_done = idx == '0;

  // The topmost cell never overflows during conversion
  a_no_top_carry: assert property (@(posedge clk) disable iff (rst)
    cmd.convert |-> !carries[itoa_pkg::NUM_CELLS])
    else $error("carry out of the top digit cell");

  // A sign word is a minus and never ends the text
  a_sign_word: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_sign |=> strobe && text_char == itoa_pkg::CHAR_MINUS && !last_char)
    else $error("sign word malformed");

  // The lowest digit closes the text
  a_last_digit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_digit && idx == '0 |=> strobe && last_char)
    else $error("final digit not marked last");

endmodule

// ===== design/integer_to_text_any_base.sv =====
// Top level: configuration registers, sequencer and conversion datapath.
// The first character on the ports is the minus on a negative value, else the top digit.
// A new value is taken only while idle, after the previous one is done; the 32-step
//   bit-serial conversion through the digit cells runs before any character is emitted.
// An invalid alphabet ends the value after the check state with no words.
// Reset clears the sequencer, output strobe and all configuration registers (alphabet invalid).
module integer_to_text_any_base (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [itoa_pkg::VALUE_BITS-1:0] value,
  input  logic                                   cfg_we,
  input  logic [itoa_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [itoa_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic [itoa_pkg::CHAR_W-1:0]            text_char,
  output logic                                   last_char,
  output logic                                   strobe
);

  logic [itoa_pkg::RADIX_W-1:0]    digit_count;
  logic [itoa_pkg::CFG_DATA_W-1:0] digit_chars_low;
  logic [itoa_pkg::CFG_DATA_W-1:0] digit_chars_high;
  itoa_pkg::ctrl_cmd_t             cmd;
  itoa_pkg::dp_status_t            status;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count      <= '0;
      digit_chars_low  <= '0;
      digit_chars_high <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        itoa_pkg::REG_DIGIT_COUNT: digit_count      <= cfg_data[itoa_pkg::RADIX_W-1:0];
        itoa_pkg::REG_CHARS_LOW:   digit_chars_low  <= cfg_data;
        itoa_pkg::REG_CHARS_HIGH:  digit_chars_high <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  itoa_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  itoa_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .value            (value),
    .digit_count      (digit_count),
    .digit_chars_low  (digit_chars_low),
    .digit_chars_high (digit_chars_high),
    .status           (status),
    .text_char        (text_char),
    .last_char        (last_char),
    .strobe           (strobe)
  );

endmodule
